@@ rtl/tzds_pkg.sv @@
// Package for the timezone date and time shift block.
// Holds the date and time record type, field widths, calendar constants and the
// leap year and month length functions. It depends on nothing else.
`default_nettype none

package tzds_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 5;

    // Wide enough for an hour in 0..31 plus an offset in -16..15.
    localparam int HSUM_W = 7;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;
    localparam logic [DAY_W-1:0]  FIRST_DAY = 5'd1;

    localparam logic signed [HSUM_W-1:0] HSUM_LAST_HOUR = 7'sd23;
    localparam logic signed [HSUM_W-1:0] HSUM_DAY_HOURS = 7'sd24;

    // Multiplicative inverse of 25 modulo 2**14 and the largest product
    // residue that marks a multiple of 25 (floor((2**14 - 1) / 25)).
    localparam logic [12:0]       INV25     = 13'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } datetime_t;

    // True when the year is a multiple of 25, by the odd-divisor residue test.
    function automatic logic div_by_25(input logic [YEAR_W-1:0] year);
        logic [26:0] prod;
        prod = 27'(year) * 27'(INV25);
        return prod[YEAR_W-1:0] <= DIV25_MAX;
    endfunction

    // Divisible by 4 and not by 100, or by 400 and not by 3200.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic d25;
        d25 = div_by_25(year);
        return ((year[1:0] == 2'd0) && !d25) ||
               ((year[3:0] == 4'd0) && d25 && (year[6:0] != 7'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                     (month == MONTH_SEP) || (month == MONTH_NOV)) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tzds_calc.sv @@
// Combinational shift of one date and time by the zone offset.
// Checks the date, then carries or borrows across day, month and year.
// Depends on tzds_pkg.
`default_nettype none

module tzds_calc (
    input  tzds_pkg::datetime_t                        dt_in,
    input  logic signed [tzds_pkg::OFFSET_W-1:0]       offset,
    output tzds_pkg::datetime_t                        dt_out,
    output logic                                       bad
);
    import tzds_pkg::*;

    logic                      leap;
    logic [DAY_W-1:0]          cur_len;
    logic [MONTH_W-1:0]        prev_month;
    logic [DAY_W-1:0]          prev_len;
    logic signed [HSUM_W-1:0]  off_ext;
    logic signed [HSUM_W-1:0]  h_sum;
    logic signed [HSUM_W-1:0]  h_wrap;

    // February is only ever looked up in the input's own year, since a
    // borrow into February comes from March of the same year.
    assign leap       = is_leap(dt_in.year);
    assign cur_len    = month_len(dt_in.month, leap);
    assign prev_month = (dt_in.month == MONTH_JAN) ? MONTH_DEC : dt_in.month - 4'd1;
    assign prev_len   = month_len(prev_month, leap);

    assign off_ext = HSUM_W'(offset);
    assign h_sum   = $signed({2'b00, dt_in.hour}) + off_ext;

    always_comb begin
        dt_out = dt_in;
        h_wrap = h_sum;
        bad    = (dt_in.month == 4'd0) || (dt_in.month > MONTH_DEC) ||
                 (dt_in.day == 5'd0) || (dt_in.day > cur_len) ||
                 (dt_in.hour > LAST_HOUR);
        if (!bad) begin
            if (h_sum > HSUM_LAST_HOUR) begin
                h_wrap = h_sum - HSUM_DAY_HOURS;
                if (dt_in.day == cur_len) begin
                    dt_out.day = FIRST_DAY;
                    if (dt_in.month == MONTH_DEC) begin
                        dt_out.month = MONTH_JAN;
                        dt_out.year  = dt_in.year + 14'd1;
                    end else begin
                        dt_out.month = dt_in.month + 4'd1;
                    end
                end else begin
                    dt_out.day = dt_in.day + 5'd1;
                end
            end else if (h_sum < 0) begin
                h_wrap = h_sum + HSUM_DAY_HOURS;
                if (dt_in.day == FIRST_DAY) begin
                    dt_out.month = prev_month;
                    dt_out.day   = prev_len;
                    if (dt_in.month == MONTH_JAN) begin
                        dt_out.year = dt_in.year - 14'd1;
                    end
                end else begin
                    dt_out.day = dt_in.day - 5'd1;
                end
            end
            dt_out.hour = h_wrap[HOUR_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/timezone_datetime_shift_top.sv @@
// Top level of the timezone date and time shift block.
// Holds the offset register, the input and result registers and the handshake.
// Depends on tzds_pkg and tzds_calc.
//
// Usage
// A date and time beat arrives on the s_ channel (valid and ready) and the
// shifted date and time leaves on the m_ channel with a flag for bad input.
// Every beat produces exactly one result beat, in order.
// The offset register is written through cfg_we and cfg_wdata; it holds a
// signed whole number of hours and should only be changed while the block
// holds no beat.
// The beat is caught in the input register at the accepting edge and passes
// through the shift logic into the result register, from which it is offered
// on the m_ channel; that move waits while the result register still holds a
// beat the receiver has not taken. Throughput is one beat per cycle while the
// receiver does not stall, set by the single combinational pass between the
// input and result registers.
// When the receiver stalls, the result register holds its beat and the input
// register may still take one more beat; after that s_ready falls until the
// receiver takes the waiting result.
// Reset (aresetn, synchronous, active low) empties both registers and
// clears the offset to zero hours.
`default_nettype none

module timezone_datetime_shift_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [tzds_pkg::OFFSET_W-1:0]         cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tzds_pkg::YEAR_W-1:0]           s_in_year,
    input  logic [tzds_pkg::MONTH_W-1:0]          s_in_month,
    input  logic [tzds_pkg::DAY_W-1:0]            s_in_day,
    input  logic [tzds_pkg::HOUR_W-1:0]           s_in_hour,
    input  logic [tzds_pkg::MINUTE_W-1:0]         s_in_minute,
    input  logic [tzds_pkg::SECOND_W-1:0]         s_in_second,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tzds_pkg::YEAR_W-1:0]           m_out_year,
    output logic [tzds_pkg::MONTH_W-1:0]          m_out_month,
    output logic [tzds_pkg::DAY_W-1:0]            m_out_day,
    output logic [tzds_pkg::HOUR_W-1:0]           m_out_hour,
    output logic [tzds_pkg::MINUTE_W-1:0]         m_out_minute,
    output logic [tzds_pkg::SECOND_W-1:0]         m_out_second,
    output logic                                  m_bad_input
);
    import tzds_pkg::*;

    logic signed [OFFSET_W-1:0] offset_reg;

    logic      in_valid_reg;
    datetime_t in_dt_reg;

    logic      out_valid_reg;
    datetime_t out_dt_reg;
    logic      out_bad_reg;

    datetime_t calc_dt;
    logic      calc_bad;
    logic      out_free;
    logic      in_advance;
    logic      s_take;

    // The result register can take a new beat when it is empty or is being
    // emptied this cycle; the input register frees up whenever it hands on.
    assign out_free   = !out_valid_reg || m_ready;
    assign in_advance = in_valid_reg && out_free;
    assign s_ready    = !in_valid_reg || out_free;
    assign s_take     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_we) begin
            offset_reg <= $signed(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_dt_reg.year   <= s_in_year;
            in_dt_reg.month  <= s_in_month;
            in_dt_reg.day    <= s_in_day;
            in_dt_reg.hour   <= s_in_hour;
            in_dt_reg.minute <= s_in_minute;
            in_dt_reg.second <= s_in_second;
        end
    end

    tzds_calc u_calc (
        .dt_in  (in_dt_reg),
        .offset (offset_reg),
        .dt_out (calc_dt),
        .bad    (calc_bad)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            out_dt_reg  <= calc_dt;
            out_bad_reg <= calc_bad;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_year   = out_dt_reg.year;
    assign m_out_month  = out_dt_reg.month;
    assign m_out_day    = out_dt_reg.day;
    assign m_out_hour   = out_dt_reg.hour;
    assign m_out_minute = out_dt_reg.minute;
    assign m_out_second = out_dt_reg.second;
    assign m_bad_input  = out_bad_reg;

    // A good result always carries a well-formed month, day and hour.
    a_good_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_bad_reg) |->
            (out_dt_reg.month != 4'd0) && (out_dt_reg.month <= MONTH_DEC) &&
            (out_dt_reg.day != 5'd0) && (out_dt_reg.hour <= LAST_HOUR))
        else $error("good result has a date or hour out of range");

    // Back-pressure only when both registers are full and the receiver stalls.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // Minute and second travel untouched from the input register.
    a_minute_second_copied: assert property (@(posedge aclk) disable iff (!aresetn)
        in_advance |=> (out_dt_reg.minute == $past(in_dt_reg.minute)) &&
                       (out_dt_reg.second == $past(in_dt_reg.second)))
        else $error("minute or second altered by the shift");

    // With no offset the hour must come out as it went in.
    a_zero_offset_keeps_hour: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_advance && (offset_reg == '0)) |=> (out_dt_reg.hour == $past(in_dt_reg.hour)))
        else $error("hour changed with a zero offset");

endmodule

`default_nettype wire
